// ----- hdl/csi_pkg.sv -----
// shared types and constants for the channel-state datagram parser
`default_nettype none
package csi_pkg;
  localparam int unsigned MaxSubcarriersDefault = 64;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned IdxW = 10;
  localparam logic [IdxW-1:0] IdxMax = 10'd1023;

  // configuration register indexes
  localparam logic [1:0] CfgMagic   = 2'd0;
  localparam logic [1:0] CfgVersion = 2'd1;
  localparam logic [1:0] CfgFirst   = 2'd2;
  localparam logic [1:0] CfgLast    = 2'd3;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StShort     = 3'd1,
    StMagic     = 3'd2,
    StVersion   = 3'd3,
    StZero      = 3'd4,
    StTooMany   = 3'd5,
    StLength    = 3'd6,
    StTruncated = 3'd7
  } status_e;

  // one classified record passed from front to back
  typedef struct packed {
    logic [7:0]  real_part;
    logic [7:0]  imag_part;
    logic        has_sample;
    logic        frame_done;
    status_e     status;
    logic [15:0] node_ident;
    logic [31:0] seq_number;
    logic [63:0] time_us;
    logic [7:0]  radio_channel;
    logic [7:0]  rssi;
    logic [7:0]  noise_floor;
    logic [1:0]  edges_dropped;
  } rec_t;
endpackage
`default_nettype wire

// ----- hdl/csi_datagram_parser.sv -----
// top level: config registers, parsing front end, record queue
// a record is written into the queue when its byte is taken; the outputs show the queue head
// throughput: one byte per cycle; the front stalls only when the two-entry queue is full
// the queue decouples the byte stream from a stalling record consumer
// reset: asynchronous, active low; parse state clears, registers take their defaults
`default_nettype none
module csi_datagram_parser #(
  parameter int unsigned MaxSubcarriers = csi_pkg::MaxSubcarriersDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        end_of_datagram_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic signed [7:0] real_part_o,
  output logic signed [7:0] imag_part_o,
  output logic             has_sample_o,
  output logic             frame_done_o,
  output logic [2:0]       status_o,
  output logic [15:0]      node_ident_o,
  output logic [31:0]      seq_number_o,
  output logic [63:0]      time_us_o,
  output logic [7:0]       radio_channel_o,
  output logic signed [7:0] rssi_o,
  output logic signed [7:0] noise_floor_o,
  output logic [1:0]       edges_dropped_o
);
  logic [15:0] magic_q;
  logic [7:0]  ver_q, fmask_q, lmask_q;
  logic        full, take, rvalid, pop;
  csi_pkg::rec_t frec, qrec;

  assign cfg_ready_o = 1'b1;
  assign stall_o = full;
  assign take = valid_i && !full;
  assign pop = valid_o && !stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0; ver_q <= '0; fmask_q <= 8'd1; lmask_q <= 8'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csi_pkg::CfgMagic:   magic_q <= cfg_data_i;
        csi_pkg::CfgVersion: ver_q <= cfg_data_i[7:0];
        csi_pkg::CfgFirst:   fmask_q <= cfg_data_i[7:0];
        csi_pkg::CfgLast:    lmask_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  csi_front #(.MaxSubcarriers(MaxSubcarriers)) u_front (
    .clk_i, .rst_ni, .take_i(take), .rx_byte_i, .end_of_datagram_i,
    .magic_i(magic_q), .version_i(ver_q), .first_mask_i(fmask_q),
    .last_mask_i(lmask_q), .rec_valid_o(rvalid), .rec_o(frec)
  );

  csi_queue u_queue (
    .clk_i, .rst_ni, .push_i(rvalid), .push_rec_i(frec), .full_o(full),
    .valid_o(valid_o), .rec_o(qrec), .pop_i(pop)
  );

  // output fields
  assign real_part_o     = qrec.real_part;
  assign imag_part_o     = qrec.imag_part;
  assign has_sample_o    = qrec.has_sample;
  assign frame_done_o    = qrec.frame_done;
  assign status_o        = qrec.status;
  assign node_ident_o    = qrec.node_ident;
  assign seq_number_o    = qrec.seq_number;
  assign time_us_o       = qrec.time_us;
  assign radio_channel_o = qrec.radio_channel;
  assign rssi_o          = qrec.rssi;
  assign noise_floor_o   = qrec.noise_floor;
  assign edges_dropped_o = qrec.edges_dropped;
endmodule
`default_nettype wire

// ----- hdl/csi_front.sv -----
// front end: byte parsing, header checks and sample pairing
`default_nettype none
module csi_front #(
  parameter int unsigned MaxSubcarriers = csi_pkg::MaxSubcarriersDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              end_of_datagram_i,
  input  wire logic [15:0]       magic_i,
  input  wire logic [7:0]        version_i,
  input  wire logic [7:0]        first_mask_i,
  input  wire logic [7:0]        last_mask_i,
  output logic                   rec_valid_o,
  output csi_pkg::rec_t          rec_o
);
  localparam int unsigned IW = csi_pkg::IdxW;

  logic [IW-1:0] idx_q, idx_d;
  logic          magic_bad_q, magic_bad_d;
  logic [2:0]    err_q, err_d;
  logic [15:0]   node_q, node_d, len_q, len_d;
  logic [31:0]   seq_q, seq_d;
  logic [63:0]   time_q, time_d;
  logic [7:0]    ver_q, ver_d, flags_q, flags_d, chan_q, chan_d;
  logic [7:0]    rssi_q, rssi_d, noise_q, noise_d, imag_q, imag_d;
  logic [7:0]    sidx_q, sidx_d;
  logic          dfirst_q, dfirst_d, dlast_q, dlast_d;

  logic [14:0]   n;
  logic [IW:0]   idx_inc;
  logic [16:0]   pay_end;
  logic          emit, skip;
  logic [2:0]    st;

  assign n       = len_q[15:1];
  assign idx_inc = (idx_q == csi_pkg::IdxMax) ? {1'b0, idx_q} : {1'b0, idx_q} + 1'b1;
  assign pay_end = 17'(csi_pkg::HeaderBytes) + {1'b0, len_q[15:1], 1'b0};

  // parse update for one byte
  always_comb begin
    logic [IW-1:0] p;
    logic [2:0]    e;
    idx_d = idx_q; magic_bad_d = magic_bad_q; err_d = err_q;
    node_d = node_q; len_d = len_q; seq_d = seq_q; time_d = time_q;
    ver_d = ver_q; flags_d = flags_q; chan_d = chan_q; rssi_d = rssi_q;
    noise_d = noise_q; imag_d = imag_q; sidx_d = sidx_q;
    dfirst_d = dfirst_q; dlast_d = dlast_q;
    emit = 1'b0; skip = 1'b0; e = csi_pkg::StOk;
    p = idx_q - IW'(csi_pkg::HeaderBytes);
    if (idx_q < IW'(csi_pkg::HeaderBytes)) begin
      case (idx_q[4:0])
        5'd0: if (rx_byte_i != magic_i[7:0]) magic_bad_d = 1'b1;
        5'd1: if (rx_byte_i != magic_i[15:8]) magic_bad_d = 1'b1;
        5'd2: ver_d = rx_byte_i;
        5'd3: flags_d = rx_byte_i;
        5'd4: node_d[7:0] = rx_byte_i;
        5'd5: node_d[15:8] = rx_byte_i;
        5'd6: len_d[7:0] = rx_byte_i;
        5'd7: len_d[15:8] = rx_byte_i;
        5'd8: seq_d[7:0] = rx_byte_i;
        5'd9: seq_d[15:8] = rx_byte_i;
        5'd10: seq_d[23:16] = rx_byte_i;
        5'd11: seq_d[31:24] = rx_byte_i;
        5'd12: time_d[7:0] = rx_byte_i;
        5'd13: time_d[15:8] = rx_byte_i;
        5'd14: time_d[23:16] = rx_byte_i;
        5'd15: time_d[31:24] = rx_byte_i;
        5'd16: time_d[39:32] = rx_byte_i;
        5'd17: time_d[47:40] = rx_byte_i;
        5'd18: time_d[55:48] = rx_byte_i;
        5'd19: time_d[63:56] = rx_byte_i;
        5'd20: chan_d = rx_byte_i;
        5'd21: rssi_d = rx_byte_i;
        5'd22: noise_d = rx_byte_i;
        default: begin
          if (magic_bad_q) e = csi_pkg::StMagic;
          else if (ver_q != version_i) e = csi_pkg::StVersion;
          else if (rx_byte_i == 8'd0) e = csi_pkg::StZero;
          else if (rx_byte_i > 8'(MaxSubcarriers)) e = csi_pkg::StTooMany;
          else if (len_q != {7'd0, rx_byte_i, 1'b0}) e = csi_pkg::StLength;
          err_d = e;
          // edge drop decisions, n equals the count byte here when the length check passes
          dfirst_d = ((flags_q & first_mask_i) != 8'd0) && (rx_byte_i > 8'd2);
          dlast_d  = ((flags_q & last_mask_i) != 8'd0) &&
                     ((rx_byte_i - {7'd0, dfirst_d}) > 8'd2);
        end
      endcase
    end else if (err_q == csi_pkg::StOk) begin
      if ({7'd0, p} < {1'b0, len_q[15:1], 1'b0}) begin
        if (!p[0]) imag_d = rx_byte_i;
        else begin
          skip = (sidx_q == 8'd0 && dfirst_q) ||
                 ({7'd0, sidx_q} == n - 15'd1 && dlast_q);
          emit = !skip;
          sidx_d = sidx_q + 8'd1;
        end
      end
    end
    idx_d = idx_inc[IW-1:0];
  end

  // closing status, header verdict of this byte included
  always_comb begin
    if (idx_d < IW'(csi_pkg::HeaderBytes)) st = csi_pkg::StShort;
    else if (err_d != csi_pkg::StOk) st = err_d;
    else if ({7'd0, idx_d} < pay_end) st = csi_pkg::StTruncated;
    else st = csi_pkg::StOk;
  end

  // record build
  always_comb begin
    logic hdr;
    rec_o = '0;
    hdr = (st == csi_pkg::StOk) || (st == csi_pkg::StTruncated);
    rec_valid_o = take_i && (emit || end_of_datagram_i);
    rec_o.has_sample = emit;
    rec_o.real_part  = emit ? rx_byte_i : 8'd0;
    rec_o.imag_part  = emit ? imag_q : 8'd0;
    if (end_of_datagram_i) begin
      rec_o.frame_done = 1'b1;
      rec_o.status = csi_pkg::status_e'(st);
      if (hdr) begin
        rec_o.node_ident = node_q; rec_o.seq_number = seq_q;
        rec_o.time_us = time_q; rec_o.radio_channel = chan_q;
        rec_o.rssi = rssi_q; rec_o.noise_floor = noise_q;
      end
      if (st == csi_pkg::StOk)
        rec_o.edges_dropped = {1'b0, dfirst_q} + {1'b0, dlast_q};
    end
  end

  // parse state, cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; magic_bad_q <= 1'b0; err_q <= '0; node_q <= '0; len_q <= '0;
      seq_q <= '0; time_q <= '0; ver_q <= '0; flags_q <= '0; chan_q <= '0;
      rssi_q <= '0; noise_q <= '0; imag_q <= '0; sidx_q <= '0;
      dfirst_q <= 1'b0; dlast_q <= 1'b0;
    end else if (take_i) begin
      if (end_of_datagram_i) begin
        idx_q <= '0; magic_bad_q <= 1'b0; err_q <= '0; node_q <= '0; len_q <= '0;
        seq_q <= '0; time_q <= '0; ver_q <= '0; flags_q <= '0; chan_q <= '0;
        rssi_q <= '0; noise_q <= '0; imag_q <= '0; sidx_q <= '0;
        dfirst_q <= 1'b0; dlast_q <= 1'b0;
      end else begin
        idx_q <= idx_d; magic_bad_q <= magic_bad_d; err_q <= err_d;
        node_q <= node_d; len_q <= len_d; seq_q <= seq_d; time_q <= time_d;
        ver_q <= ver_d; flags_q <= flags_d; chan_q <= chan_d; rssi_q <= rssi_d;
        noise_q <= noise_d; imag_q <= imag_d; sidx_q <= sidx_d;
        dfirst_q <= dfirst_d; dlast_q <= dlast_d;
      end
    end
  end

  // samples only follow a good header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && rec_o.has_sample |-> err_q == csi_pkg::StOk)
    else $error("sample after failed header");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && end_of_datagram_i |=> idx_q == '0)
    else $error("parse state not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && rec_o.edges_dropped != 2'd0 |-> rec_o.status == csi_pkg::StOk)
    else $error("edges dropped on bad frame");
endmodule
`default_nettype wire

// ----- hdl/csi_queue.sv -----
// two-entry record queue between front and output
`default_nettype none
module csi_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire csi_pkg::rec_t push_rec_i,
  output logic          full_o,
  output logic          valid_o,
  output csi_pkg::rec_t rec_o,
  input  wire logic     pop_i
);
  csi_pkg::rec_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rec_o   = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_rec_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !valid_o))
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count corrupt");
endmodule
`default_nettype wire
